### hdl/kruskal_minimum_spanning_tree_assert.svh
// Assertion macros for the spanning tree block.
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_ASSERT_SVH
`ifndef SYNTHESIS
`define KMST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmst implication check failed");
`define KMST_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("kmst forbidden condition seen");
`else
`define KMST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define KMST_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### hdl/kmst_pkg.sv
// Shared types and constants for the spanning tree block.
package kmst_pkg;

    localparam int VERT_W   = 6;
    localparam int WEIGHT_W = 32;
    localparam int COST_W   = 38;
    localparam int VCOUNT_W = 7;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 1024;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [VCOUNT_W-1:0] VCOUNT_MIN   = 7'd2;

    // One classified request from the front
    typedef struct packed {
        logic [VERT_W-1:0]          a;
        logic [VERT_W-1:0]          b;
        logic signed [WEIGHT_W-1:0] w;
        logic                       keep;
        logic                       last;
    } cmd_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK,
        ST_JOIN,
        ST_PUSH,
        ST_SWEEP,
        ST_FINISH
    } back_state_t;

endpackage

### hdl/kruskal_minimum_spanning_tree.sv
// Top level of the Kruskal minimum spanning tree block.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+------------------------------------------
//  load     | load_valid / load_ready     | vertex_a, vertex_b, edge_weight, last_edge
//  result   | result_valid / result_ready | tree_a, tree_b, tree_weight, total_cost,
//           |                             | edge_valid, dropped_any, final_result
//  cfg      | cfg_valid / cfg_ready       | cfg_data (vertex_count)
//
// Edges load at one request per cycle into the edge store memory.
// After the last edge a run makes one full pass over the edge store memory per visited
// edge, plus one relabel pass over the set label memory per selected edge.
// Reset needs no clearing pass; the block loads right after reset.
// Loading stalls while a run is in progress once the request queue fills.
module kruskal_minimum_spanning_tree
#(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load_valid,
    output logic                                  load_ready,
    input  logic [kmst_pkg::VERT_W-1:0]           vertex_a,
    input  logic [kmst_pkg::VERT_W-1:0]           vertex_b,
    input  logic signed [kmst_pkg::WEIGHT_W-1:0]  edge_weight,
    input  logic                                  last_edge,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [kmst_pkg::VERT_W-1:0]           tree_a,
    output logic [kmst_pkg::VERT_W-1:0]           tree_b,
    output logic signed [kmst_pkg::WEIGHT_W-1:0]  tree_weight,
    output logic signed [kmst_pkg::COST_W-1:0]    total_cost,
    output logic                                  edge_valid,
    output logic                                  dropped_any,
    output logic                                  final_result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kmst_pkg::VCOUNT_W-1:0]         cfg_data
);

`include "kruskal_minimum_spanning_tree_assert.svh"

    localparam int VCW = kmst_pkg::VCOUNT_W;

    logic [VCW-1:0]   vcount_reg;
    logic [VCW-1:0]   vcount_next;
    logic [VCW-1:0]   n_eff;
    logic             q_push;
    logic             q_pop;
    kmst_pkg::cmd_t   q_in;
    kmst_pkg::cmd_t   q_out;
    kmst_pkg::qstat_t q_stat;

    assign cfg_ready = 1'b1;

    // Vertex count register
    assign vcount_next = (cfg_valid && cfg_ready) ? cfg_data : vcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= kmst_pkg::VCOUNT_RESET;
        end
        else
        begin
            vcount_reg <= vcount_next;
        end
    end

    // Clamp to the supported vertex range
    always_comb
    begin
        priority if (vcount_reg < kmst_pkg::VCOUNT_MIN)
        begin
            n_eff = kmst_pkg::VCOUNT_MIN;
        end
        else if (vcount_reg > VCW'(MAX_VERTICES))
        begin
            n_eff = VCW'(MAX_VERTICES);
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end

    kmst_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .n_eff       (n_eff),
        .load_valid  (load_valid),
        .load_ready  (load_ready),
        .vertex_a    (vertex_a),
        .vertex_b    (vertex_b),
        .edge_weight (edge_weight),
        .last_edge   (last_edge),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_cmd       (q_in)
    );

    kmst_queue #(.DEPTH(kmst_pkg::QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .pop_cmd  (q_out),
        .stat     (q_stat)
    );

    kmst_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .n_eff        (n_eff),
        .q_stat       (q_stat),
        .q_cmd        (q_out),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .tree_a       (tree_a),
        .tree_b       (tree_b),
        .tree_weight  (tree_weight),
        .total_cost   (total_cost),
        .edge_valid   (edge_valid),
        .dropped_any  (dropped_any),
        .final_result (final_result)
    );

    // Checks
    `KMST_ASSERT_IMPL(a_empty_is_final, clk, rst_n, result_valid && !edge_valid, final_result)
    `KMST_ASSERT_IMPL(a_empty_is_zero, clk, rst_n, result_valid && !edge_valid, (total_cost == '0) && (tree_weight == '0))
    `KMST_ASSERT_NEVER(a_queue_status, clk, rst_n, q_stat.full && q_stat.empty)

endmodule

### hdl/kmst_front.sv
// Front end: input register and range classification of loaded edges.
module kmst_front
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [kmst_pkg::VCOUNT_W-1:0]        n_eff,
    input  logic                                 load_valid,
    output logic                                 load_ready,
    input  logic [kmst_pkg::VERT_W-1:0]          vertex_a,
    input  logic [kmst_pkg::VERT_W-1:0]          vertex_b,
    input  logic signed [kmst_pkg::WEIGHT_W-1:0] edge_weight,
    input  logic                                 last_edge,
    input  kmst_pkg::qstat_t                     q_stat,
    output logic                                 q_push,
    output kmst_pkg::cmd_t                       q_cmd
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    kmst_pkg::cmd_t hold_reg;
    logic           take;

    // Stage is free when empty or draining into the queue
    assign q_push     = hold_valid_reg && !q_stat.full;
    assign load_ready = !hold_valid_reg || !q_stat.full;
    assign take       = load_valid && load_ready;
    assign q_cmd      = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Classify: both endpoints below the active vertex count
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg.a    <= vertex_a;
            hold_reg.b    <= vertex_b;
            hold_reg.w    <= edge_weight;
            hold_reg.last <= last_edge;
            hold_reg.keep <= ({1'b0, vertex_a} < n_eff) && ({1'b0, vertex_b} < n_eff);
        end
    end

endmodule

### hdl/kmst_queue.sv
// Short request queue between front and back.
module kmst_queue
#(
    parameter int DEPTH = kmst_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kmst_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output kmst_pkg::cmd_t   pop_cmd,
    output kmst_pkg::qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kmst_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hdl/kmst_back.sv
// Back end: edge store, ordered scan, set labels and result register.
module kmst_back
#(
    parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [kmst_pkg::VCOUNT_W-1:0]         n_eff,
    input  kmst_pkg::qstat_t                      q_stat,
    input  kmst_pkg::cmd_t                        q_cmd,
    output logic                                  q_pop,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [kmst_pkg::VERT_W-1:0]           tree_a,
    output logic [kmst_pkg::VERT_W-1:0]           tree_b,
    output logic signed [kmst_pkg::WEIGHT_W-1:0]  tree_weight,
    output logic signed [kmst_pkg::COST_W-1:0]    total_cost,
    output logic                                  edge_valid,
    output logic                                  dropped_any,
    output logic                                  final_result
);

    localparam int VW     = kmst_pkg::VERT_W;
    localparam int WW     = kmst_pkg::WEIGHT_W;
    localparam int CW     = kmst_pkg::COST_W;
    localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int KEY_W  = WW + ADDR_W;
    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int SW_W   = $clog2(MAX_VERTICES + 1);
    localparam int WORD_W = WW + 2 * VW;

    kmst_pkg::back_state_t state_reg;
    kmst_pkg::back_state_t state_next;

    // Edge store
    logic [WORD_W-1:0] edge_mem [MAX_EDGES];
    logic [WORD_W-1:0] mem_data_reg;
    logic              mem_we;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              drop_reg;
    logic              drop_next;

    // Scan
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [CNT_W-1:0]  scan_idx_next;
    logic              scan_issue;
    logic              scan_done;
    logic              rd_vld_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [KEY_W-1:0]  cand_key;
    logic              have_prev_reg;
    logic              have_prev_next;
    logic [KEY_W-1:0]  prev_key_reg;
    logic [KEY_W-1:0]  prev_key_next;
    logic              best_found_reg;
    logic              best_found_next;
    logic [KEY_W-1:0]  best_key_reg;
    logic [KEY_W-1:0]  best_key_next;
    logic [VW-1:0]     best_a_reg;
    logic [VW-1:0]     best_a_next;
    logic [VW-1:0]     best_b_reg;
    logic [VW-1:0]     best_b_next;
    logic signed [WW-1:0] best_w_reg;
    logic signed [WW-1:0] best_w_next;
    logic              best_bad;

    // Set labels
    logic [VID_W-1:0]        comp_mem [MAX_VERTICES];
    logic [VID_W-1:0]        comp_a_reg;
    logic [VID_W-1:0]        comp_b_reg;
    logic [VID_W-1:0]        comp_rd_a;
    logic [MAX_VERTICES-1:0] lbl_vld_reg;
    logic [MAX_VERTICES-1:0] lbl_vld_next;
    logic [VID_W-1:0]        best_a_id;
    logic [VID_W-1:0]        best_b_id;
    logic [VID_W-1:0]        lbl_a;
    logic [VID_W-1:0]        lbl_b;
    logic [VID_W-1:0]        from_reg;
    logic [VID_W-1:0]        from_next;
    logic [VID_W-1:0]        to_reg;
    logic [VID_W-1:0]        to_next;
    logic [SW_W-1:0]         sweep_idx_reg;
    logic [SW_W-1:0]         sweep_idx_next;
    logic                    sweep_issue;
    logic                    sweep_done;
    logic                    sw_vld_reg;
    logic [VID_W-1:0]        sw_d_reg;
    logic [VID_W-1:0]        sw_lbl;
    logic                    comp_we;

    // Results
    logic signed [CW-1:0] cost_reg;
    logic signed [CW-1:0] cost_next;
    logic                 pend_vld_reg;
    logic                 pend_vld_next;
    logic [VW-1:0]        pend_a_reg;
    logic [VW-1:0]        pend_b_reg;
    logic signed [WW-1:0] pend_w_reg;
    logic signed [CW-1:0] pend_cost_reg;
    logic                 pend_drop_reg;
    logic                 pend_load;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 out_free;
    logic                 out_load;
    logic                 out_final;

    assign out_free    = !out_vld_reg || result_ready;
    assign result_valid = out_vld_reg;

    assign scan_issue = (state_reg == kmst_pkg::ST_SCAN) && (scan_idx_reg < cnt_reg);
    assign scan_done  = (state_reg == kmst_pkg::ST_SCAN) && !scan_issue && !rd_vld_reg;
    assign cand_key   = {~mem_data_reg[WORD_W-1], mem_data_reg[WORD_W-2:2*VW], rd_idx_reg};
    assign best_bad   = ({1'b0, best_a_reg} >= n_eff) || ({1'b0, best_b_reg} >= n_eff);

    assign best_a_id = best_a_reg[VID_W-1:0];
    assign best_b_id = best_b_reg[VID_W-1:0];
    assign lbl_a     = lbl_vld_reg[best_a_id] ? comp_a_reg : best_a_id;
    assign lbl_b     = lbl_vld_reg[best_b_id] ? comp_b_reg : best_b_id;

    assign sweep_issue = (state_reg == kmst_pkg::ST_SWEEP) &&
                         (sweep_idx_reg < SW_W'(MAX_VERTICES));
    assign sweep_done  = (state_reg == kmst_pkg::ST_SWEEP) && !sweep_issue && !sw_vld_reg;
    assign sw_lbl      = lbl_vld_reg[sw_d_reg] ? comp_a_reg : sw_d_reg;
    assign comp_we     = sw_vld_reg && (sw_lbl == from_reg);
    assign comp_rd_a   = (state_reg == kmst_pkg::ST_PICK) ? best_a_id
                                                          : sweep_idx_reg[VID_W-1:0];

    assign q_pop  = (state_reg == kmst_pkg::ST_LOAD) && !q_stat.empty;
    assign mem_we = q_pop && q_cmd.keep && (cnt_reg < CNT_W'(MAX_EDGES));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmst_pkg::ST_LOAD:
            begin
                if (q_pop && q_cmd.last)
                begin
                    state_next = kmst_pkg::ST_SCAN;
                end
            end
            kmst_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = kmst_pkg::ST_PICK;
                end
            end
            kmst_pkg::ST_PICK:
            begin
                priority if (!best_found_reg)
                begin
                    state_next = kmst_pkg::ST_FINISH;
                end
                else if (best_bad)
                begin
                    state_next = kmst_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = kmst_pkg::ST_JOIN;
                end
            end
            kmst_pkg::ST_JOIN:
            begin
                state_next = (lbl_a == lbl_b) ? kmst_pkg::ST_SCAN : kmst_pkg::ST_PUSH;
            end
            kmst_pkg::ST_PUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    state_next = kmst_pkg::ST_SWEEP;
                end
            end
            kmst_pkg::ST_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = kmst_pkg::ST_SCAN;
                end
            end
            kmst_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = kmst_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = kmst_pkg::ST_LOAD;
            end
        endcase
    end

    // Datapath and control outputs
    always_comb
    begin
        cnt_next        = cnt_reg;
        drop_next       = drop_reg;
        scan_idx_next   = scan_idx_reg;
        have_prev_next  = have_prev_reg;
        prev_key_next   = prev_key_reg;
        best_found_next = best_found_reg;
        best_key_next   = best_key_reg;
        best_a_next     = best_a_reg;
        best_b_next     = best_b_reg;
        best_w_next     = best_w_reg;
        lbl_vld_next    = lbl_vld_reg;
        from_next       = from_reg;
        to_next         = to_reg;
        sweep_idx_next  = sweep_idx_reg;
        cost_next       = cost_reg;
        pend_vld_next   = pend_vld_reg;
        pend_load       = 1'b0;
        out_load        = 1'b0;
        out_final       = 1'b0;
        out_vld_next    = out_vld_reg && !result_ready;

        // Loading
        if (q_pop)
        begin
            if (mem_we)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
            if (q_cmd.last)
            begin
                have_prev_next = 1'b0;
            end
        end

        // Scan: smallest key above the previous one
        if (scan_issue)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (rd_vld_reg)
        begin
            if ((!have_prev_reg || cand_key > prev_key_reg) &&
                (!best_found_reg || cand_key < best_key_reg))
            begin
                best_found_next = 1'b1;
                best_key_next   = cand_key;
                best_a_next     = mem_data_reg[VW-1:0];
                best_b_next     = mem_data_reg[2*VW-1:VW];
                best_w_next     = mem_data_reg[WORD_W-1:2*VW];
            end
        end

        // Pick the edge found by the scan
        if (state_reg == kmst_pkg::ST_PICK && best_found_reg)
        begin
            have_prev_next = 1'b1;
            prev_key_next  = best_key_reg;
            if (best_bad)
            begin
                drop_next = 1'b1;
            end
        end

        // Join: endpoints in separate sets
        if (state_reg == kmst_pkg::ST_JOIN && lbl_a != lbl_b)
        begin
            from_next = lbl_b;
            to_next   = lbl_a;
            cost_next = cost_reg + CW'(best_w_reg);
        end

        // Hand the held result out, hold the new one
        if (state_reg == kmst_pkg::ST_PUSH && (!pend_vld_reg || out_free))
        begin
            out_load       = pend_vld_reg;
            pend_load      = 1'b1;
            pend_vld_next  = 1'b1;
            sweep_idx_next = '0;
        end

        // Relabel pass
        if (sweep_issue)
        begin
            sweep_idx_next = sweep_idx_reg + 1'b1;
        end
        if (comp_we)
        begin
            lbl_vld_next[sw_d_reg] = 1'b1;
        end

        // End of run
        if (state_reg == kmst_pkg::ST_FINISH && out_free)
        begin
            out_load      = 1'b1;
            out_final     = 1'b1;
            cnt_next      = '0;
            drop_next     = 1'b0;
            cost_next     = '0;
            pend_vld_next = 1'b0;
            lbl_vld_next  = '0;
        end
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end

        // Fresh scan on every entry
        if (state_next == kmst_pkg::ST_SCAN && state_reg != kmst_pkg::ST_SCAN)
        begin
            scan_idx_next   = '0;
            best_found_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kmst_pkg::ST_LOAD;
            cnt_reg        <= '0;
            drop_reg       <= 1'b0;
            scan_idx_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            have_prev_reg  <= 1'b0;
            best_found_reg <= 1'b0;
            lbl_vld_reg    <= '0;
            sweep_idx_reg  <= '0;
            sw_vld_reg     <= 1'b0;
            cost_reg       <= '0;
            pend_vld_reg   <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            drop_reg       <= drop_next;
            scan_idx_reg   <= scan_idx_next;
            rd_vld_reg     <= scan_issue;
            have_prev_reg  <= have_prev_next;
            best_found_reg <= best_found_next;
            lbl_vld_reg    <= lbl_vld_next;
            sweep_idx_reg  <= sweep_idx_next;
            sw_vld_reg     <= sweep_issue;
            cost_reg       <= cost_next;
            pend_vld_reg   <= pend_vld_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= scan_idx_reg[ADDR_W-1:0];
        sw_d_reg     <= sweep_idx_reg[VID_W-1:0];
        prev_key_reg <= prev_key_next;
        best_key_reg <= best_key_next;
        best_a_reg   <= best_a_next;
        best_b_reg   <= best_b_next;
        best_w_reg   <= best_w_next;
        from_reg     <= from_next;
        to_reg       <= to_next;
        if (pend_load)
        begin
            pend_a_reg    <= best_a_reg;
            pend_b_reg    <= best_b_reg;
            pend_w_reg    <= best_w_reg;
            pend_cost_reg <= cost_reg;
            pend_drop_reg <= drop_reg;
        end
        if (out_load)
        begin
            final_result <= out_final;
            if (pend_vld_reg)
            begin
                tree_a      <= pend_a_reg;
                tree_b      <= pend_b_reg;
                tree_weight <= pend_w_reg;
                total_cost  <= pend_cost_reg;
                edge_valid  <= 1'b1;
                dropped_any <= pend_drop_reg;
            end
            else
            begin
                tree_a      <= '0;
                tree_b      <= '0;
                tree_weight <= '0;
                total_cost  <= '0;
                edge_valid  <= 1'b0;
                dropped_any <= drop_reg;
            end
        end
    end

    // Edge store memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[cnt_reg[ADDR_W-1:0]] <= {q_cmd.w, q_cmd.b, q_cmd.a};
        end
        if (scan_issue)
        begin
            mem_data_reg <= edge_mem[scan_idx_reg[ADDR_W-1:0]];
        end
    end

    // Set label memory
    always_ff @(posedge clk)
    begin
        if (comp_we)
        begin
            comp_mem[sw_d_reg] <= to_reg;
        end
        comp_a_reg <= comp_mem[comp_rd_a];
        comp_b_reg <= comp_mem[best_b_id];
    end

endmodule
